// ===== rtl/core/thermal_tier_governor_assert.svh =====
// Assertion macros used by the thermal tier governor back end
`ifndef THERMAL_TIER_GOVERNOR_ASSERT_SVH
`define THERMAL_TIER_GOVERNOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clk, off while in reset
`define TTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, clocked on clk, off while in reset
`define TTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TTG_ASSERT_IMP(lbl, ante, cons, msg)
`define TTG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ttg_pkg.sv =====
// Shared types, constants and register map of the thermal tier governor
`default_nettype none
package ttg_pkg;

  // Default structural parameters
  localparam int TIME_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Field widths
  localparam int NOW_W   = 32;
  localparam int TEMP_W  = 19;
  localparam int THR_W   = 18;
  localparam int HOLD_W  = 20;
  localparam int POLL_W  = 16;
  localparam int SCALE_W = 17;
  localparam int TIER_W  = 2;

  // APB register port
  localparam int ADDR_W  = 5;
  localparam int PDATA_W = 32;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_HOT_THR   = 3'd1;
  localparam logic [2:0] REG_COOL_THR  = 3'd2;
  localparam logic [2:0] REG_COOL_HOLD = 3'd3;
  localparam logic [2:0] REG_POLL_IV   = 3'd4;
  localparam logic [2:0] REG_SCALE0    = 3'd5;
  localparam logic [2:0] REG_SCALE1    = 3'd6;
  localparam logic [2:0] REG_SCALE2    = 3'd7;

  // Register reset values
  localparam logic [THR_W-1:0]   HOT_THR_RST   = 18'd78000;
  localparam logic [THR_W-1:0]   COOL_THR_RST  = 18'd66000;
  localparam logic [HOLD_W-1:0]  COOL_HOLD_RST = 20'd45000;
  localparam logic [POLL_W-1:0]  POLL_IV_RST   = 16'd3000;
  localparam logic [SCALE_W-1:0] SCALE0_RST    = 17'd65536;
  localparam logic [SCALE_W-1:0] SCALE1_RST    = 17'd43254;
  localparam logic [SCALE_W-1:0] SCALE2_RST    = 17'd32768;

  // Tiers
  localparam logic [SCALE_W-1:0] FULL_SCALE = 17'd65536;
  localparam logic [TIER_W-1:0]  TIER_FULL  = 2'd0;
  localparam logic [TIER_W-1:0]  TIER_MID   = 2'd1;
  localparam logic [TIER_W-1:0]  TIER_MAX   = 2'd2;

  // Classification of one reading, made by the front end
  typedef struct packed {
    logic good;   // sensor ok and reading above zero
    logic hot;    // at or above the hot threshold
    logic cool;   // at or below the cool threshold
  } ttg_class_t;

  localparam int CLASS_W     = $bits(ttg_class_t);
  localparam int ENT_FIXED_W = CLASS_W + TEMP_W;

endpackage
`default_nettype wire

// ===== rtl/core/ttg_front.sv =====
// Front end: accepts update requests and classifies the reading
`default_nettype none
module ttg_front import ttg_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [NOW_W-1:0]                 in_now_ms,
  input  logic                             in_read_ok,
  input  logic signed [TEMP_W-1:0]         in_temp_milli,
  input  logic [THR_W-1:0]                 hot_thr,
  input  logic [THR_W-1:0]                 cool_thr,
  input  logic                             q_ready,
  output logic                             q_push,
  output logic [TIME_BITS+ENT_FIXED_W-1:0] q_data
);

  ttg_class_t             cls;
  logic [TIME_BITS-1:0]   now_t;
  logic signed [TEMP_W-1:0] hot_s;
  logic signed [TEMP_W-1:0] cool_s;

  // Take a request whenever the queue has room
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // Keep the low time bits (zero-extend for wider time bases)
  assign now_t = TIME_BITS'(in_now_ms);

  // Compare the reading against both thresholds as signed values
  assign hot_s    = $signed({1'b0, hot_thr});
  assign cool_s   = $signed({1'b0, cool_thr});
  assign cls.good = in_read_ok && !in_temp_milli[TEMP_W-1] && (in_temp_milli != '0);
  assign cls.hot  = in_temp_milli >= hot_s;
  assign cls.cool = in_temp_milli <= cool_s;

  assign q_data = {now_t, cls, in_temp_milli};

endmodule
`default_nettype wire

// ===== rtl/core/ttg_queue.sv =====
// Short flop queue between the front end and the governor back end
`default_nettype none
module ttg_queue import ttg_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry; payload needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ttg_back.sv =====
// Back end: governor state, tier decision and the result register
`default_nettype none
`include "thermal_tier_governor_assert.svh"
module ttg_back import ttg_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  logic [TIME_BITS+ENT_FIXED_W-1:0] q_data,
  input  logic                             enable,
  input  logic [HOLD_W-1:0]                cool_hold,
  input  logic [POLL_W-1:0]                poll_iv,
  input  logic [SCALE_W-1:0]               scale0,
  input  logic [SCALE_W-1:0]               scale1,
  input  logic [SCALE_W-1:0]               scale2,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [SCALE_W-1:0]               out_scale_q16,
  output logic [TIER_W-1:0]                out_tier,
  output logic                             out_polled,
  output logic                             out_stepped_down,
  output logic                             out_stepped_up,
  output logic signed [TEMP_W-1:0]         out_last_temp_out
);

  localparam int CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

  logic [TIME_BITS-1:0]     d_now;
  ttg_class_t               d_cls;
  logic [TEMP_W-1:0]        d_temp;

  logic [TIER_W-1:0]        tier_r, tier_nxt;
  logic [TIME_BITS-1:0]     last_poll_r, last_poll_nxt;
  logic [TIME_BITS-1:0]     cool_start_r, cool_start_nxt;
  logic                     cool_armed_r, cool_armed_nxt;
  logic [TEMP_W-1:0]        last_good_r, last_good_nxt;

  logic                     out_valid_r;
  logic [SCALE_W-1:0]       scale_r, scale_nxt;
  logic [TIER_W-1:0]        out_tier_r;
  logic                     polled_r, polled_nxt;
  logic                     down_r, down_nxt;
  logic                     up_r, up_nxt;
  logic [TEMP_W-1:0]        out_temp_r;

  logic [TIME_BITS-1:0]     poll_gap;
  logic [TIME_BITS-1:0]     cool_gap;
  logic                     poll_due;
  logic                     hold_done;

  assign {d_now, d_cls, d_temp} = q_data;

  // Pop when the result register is free or being emptied
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Wrapping elapsed times
  assign poll_gap  = d_now - last_poll_r;
  assign cool_gap  = d_now - cool_start_r;
  assign poll_due  = poll_gap >= TIME_BITS'(poll_iv);
  assign hold_done = CMP_W'(cool_gap) >= CMP_W'(cool_hold);

  // Decide the tier step for one update
  always_comb begin
    tier_nxt       = tier_r;
    last_poll_nxt  = last_poll_r;
    cool_start_nxt = cool_start_r;
    cool_armed_nxt = cool_armed_r;
    last_good_nxt  = last_good_r;
    polled_nxt     = 1'b0;
    down_nxt       = 1'b0;
    up_nxt         = 1'b0;
    if (enable && poll_due) begin
      polled_nxt    = 1'b1;
      last_poll_nxt = d_now;
      if (d_cls.good) begin
        last_good_nxt = d_temp;
        if (d_cls.hot && (tier_r < TIER_MAX)) begin
          tier_nxt       = tier_r + 1'b1;
          cool_armed_nxt = 1'b0;
          down_nxt       = 1'b1;
        end else if (d_cls.cool && (tier_r != TIER_FULL)) begin
          if (!cool_armed_r) begin
            cool_armed_nxt = 1'b1;
            cool_start_nxt = d_now;
          end else if (hold_done) begin
            tier_nxt       = tier_r - 1'b1;
            cool_armed_nxt = 1'b0;
            up_nxt         = 1'b1;
          end
        end else begin
          cool_armed_nxt = 1'b0;
        end
      end
    end
  end

  // Look up the scale of the resulting tier (full scale while disabled)
  always_comb begin
    if (!enable) begin
      scale_nxt = FULL_SCALE;
    end else begin
      case (tier_nxt)
        TIER_FULL: scale_nxt = scale0;
        TIER_MID:  scale_nxt = scale1;
        default:   scale_nxt = scale2;
      endcase
    end
  end

  // Hold the governor state between updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tier_r       <= TIER_FULL;
      last_poll_r  <= '0;
      cool_start_r <= '0;
      cool_armed_r <= 1'b0;
      last_good_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        tier_r       <= tier_nxt;
        last_poll_r  <= last_poll_nxt;
        cool_start_r <= cool_start_nxt;
        cool_armed_r <= cool_armed_nxt;
        last_good_r  <= last_good_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      scale_r    <= scale_nxt;
      out_tier_r <= tier_nxt;
      polled_r   <= polled_nxt;
      down_r     <= down_nxt;
      up_r       <= up_nxt;
      out_temp_r <= last_good_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scale_q16     = scale_r;
  assign out_tier          = out_tier_r;
  assign out_polled        = polled_r;
  assign out_stepped_down  = down_r;
  assign out_stepped_up    = up_r;
  assign out_last_temp_out = $signed(out_temp_r);

  `TTG_ASSERT_IMP(a_step_excl, out_valid_r, !(down_r && up_r), "step up and down together")
  `TTG_ASSERT_IMP(a_down_tier, out_valid_r && down_r, out_tier_r != TIER_FULL, "step down to tier 0")
  `TTG_ASSERT_NXT(a_dis_hold, q_pop && !enable, $stable(tier_r) && $stable(last_poll_r) && $stable(cool_armed_r), "state moved while disabled")
  `TTG_ASSERT_NXT(a_hot_down, q_pop && enable && poll_due && d_cls.good && d_cls.hot && (tier_r != TIER_MAX), out_valid_r && down_r, "hot poll did not step down")

endmodule
`default_nettype wire

// ===== rtl/core/thermal_tier_governor.sv =====
// Top level of the thermal tier governor: register file, front end, queue, back end
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  in       | in_valid/in_ready   | in_now_ms, in_read_ok, in_temp_milli
//  out      | out_valid/out_ready | out_scale_q16, out_tier, out_polled,
//           |                     | out_stepped_down, out_stepped_up, out_last_temp_out
//  cfg      | psel/penable/pready | paddr, pwrite, pwdata, prdata (APB, 4*index)
//
// One request per cycle sustained while out_ready stays high; a result is held in a queue entry
// and then in the back-end result register.
// The rate is set by the state update in the back end.
// Reset is synchronous, active low; it clears the tier state and loads the default registers.
// The queue lets requests keep arriving while a result stalls until it fills.
`default_nettype none
module thermal_tier_governor import ttg_pkg::*; #(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [NOW_W-1:0]         in_now_ms,
  input  logic                     in_read_ok,
  input  logic signed [TEMP_W-1:0] in_temp_milli,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SCALE_W-1:0]       out_scale_q16,
  output logic [TIER_W-1:0]        out_tier,
  output logic                     out_polled,
  output logic                     out_stepped_down,
  output logic                     out_stepped_up,
  output logic signed [TEMP_W-1:0] out_last_temp_out,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam int ENT_W = TIME_BITS + ENT_FIXED_W;

  logic                 enable_r;
  logic [THR_W-1:0]     hot_thr_r;
  logic [THR_W-1:0]     cool_thr_r;
  logic [HOLD_W-1:0]    cool_hold_r;
  logic [POLL_W-1:0]    poll_iv_r;
  logic [SCALE_W-1:0]   scale0_r;
  logic [SCALE_W-1:0]   scale1_r;
  logic [SCALE_W-1:0]   scale2_r;

  logic                 wr_en;
  logic [2:0]           reg_idx;
  logic                 q_push;
  logic                 q_ready;
  logic [ENT_W-1:0]     q_wdata;
  logic                 q_valid;
  logic                 q_pop;
  logic [ENT_W-1:0]     q_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      hot_thr_r   <= HOT_THR_RST;
      cool_thr_r  <= COOL_THR_RST;
      cool_hold_r <= COOL_HOLD_RST;
      poll_iv_r   <= POLL_IV_RST;
      scale0_r    <= SCALE0_RST;
      scale1_r    <= SCALE1_RST;
      scale2_r    <= SCALE2_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:    enable_r    <= pwdata[0];
        REG_HOT_THR:   hot_thr_r   <= pwdata[THR_W-1:0];
        REG_COOL_THR:  cool_thr_r  <= pwdata[THR_W-1:0];
        REG_COOL_HOLD: cool_hold_r <= pwdata[HOLD_W-1:0];
        REG_POLL_IV:   poll_iv_r   <= pwdata[POLL_W-1:0];
        REG_SCALE0:    scale0_r    <= pwdata[SCALE_W-1:0];
        REG_SCALE1:    scale1_r    <= pwdata[SCALE_W-1:0];
        REG_SCALE2:    scale2_r    <= pwdata[SCALE_W-1:0];
        default:       ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx)
      REG_ENABLE:    prdata = PDATA_W'(enable_r);
      REG_HOT_THR:   prdata = PDATA_W'(hot_thr_r);
      REG_COOL_THR:  prdata = PDATA_W'(cool_thr_r);
      REG_COOL_HOLD: prdata = PDATA_W'(cool_hold_r);
      REG_POLL_IV:   prdata = PDATA_W'(poll_iv_r);
      REG_SCALE0:    prdata = PDATA_W'(scale0_r);
      REG_SCALE1:    prdata = PDATA_W'(scale1_r);
      REG_SCALE2:    prdata = PDATA_W'(scale2_r);
      default:       prdata = '0;
    endcase
  end

  ttg_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_now_ms     (in_now_ms),
    .in_read_ok    (in_read_ok),
    .in_temp_milli (in_temp_milli),
    .hot_thr       (hot_thr_r),
    .cool_thr      (cool_thr_r),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  ttg_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_wdata),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_rdata)
  );

  ttg_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_data            (q_rdata),
    .enable            (enable_r),
    .cool_hold         (cool_hold_r),
    .poll_iv           (poll_iv_r),
    .scale0            (scale0_r),
    .scale1            (scale1_r),
    .scale2            (scale2_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scale_q16     (out_scale_q16),
    .out_tier          (out_tier),
    .out_polled        (out_polled),
    .out_stepped_down  (out_stepped_down),
    .out_stepped_up    (out_stepped_up),
    .out_last_temp_out (out_last_temp_out)
  );

endmodule
`default_nettype wire
